@@ rtl/lccd_pkg.sv @@
// ---------------------------------------------------------------------------
// lccd_pkg: shared types and constants of the linear CCD frame builder
// Payload structs, register indexes, frame geometry, header words and the
// reciprocal constants used for the fixed divisions.
// ---------------------------------------------------------------------------
package lccd_pkg;

   // frame geometry
   localparam int PIXELS_OUT        = 1000;
   localparam int SAMPLES_PER_FRAME = 1546;
   localparam int DARK_COUNT        = 14;
   localparam int LEAD_SAMPLES      = 32;
   localparam int FULL_SPAN         = 1500;

   localparam int WIN_START = LEAD_SAMPLES +
                              ((PIXELS_OUT <= FULL_SPAN) ? (FULL_SPAN - PIXELS_OUT) / 2 : 0);
   localparam int WIN_END   = WIN_START + PIXELS_OUT - 1;

   localparam int IDX_W = 11;

   // header words
   localparam logic [15:0] HEAD_WORD = 16'h2107;
   localparam logic [15:0] TAIL_WORD = 16'h0721;
   localparam logic [15:0] PIX_WORD  = 16'(PIXELS_OUT);
   localparam logic [7:0]  MODE_BYTE = 8'd1;

   // reset values of the configuration registers
   localparam logic [15:0] EXPOSURE_RST = 16'd2000;
   localparam logic [3:0]  WARMUP_RST   = 4'd5;
   localparam logic [3:0]  FRAMES_MAX   = 4'hF;

   // dark mean: sum * ceil(2^21 / DARK_COUNT) >> 21 is exact for 16-bit sums
   localparam int          DARK_SHIFT = 21;
   localparam logic [21:0] DARK_RECIP = 22'((2**DARK_SHIFT + DARK_COUNT - 1) / DARK_COUNT);

   // pixel: diff * ceil(2^16 / 10) >> 16 is exact for 12-bit differences
   localparam int          PIX_DIVISOR = 10;
   localparam int          PIX_SHIFT   = 16;
   localparam logic [15:0] PIX_RECIP   = 16'((2**PIX_SHIFT + PIX_DIVISOR - 1) / PIX_DIVISOR);

   // queue between front and back
   localparam int QDEPTH = 16;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef enum logic {
      CSR_EXPOSURE = 1'b0,
      CSR_WARMUP   = 1'b1
   } csr_addr_type;

   typedef enum logic [3:0] {
      BYTE_HEAD_LO = 4'd0,
      BYTE_HEAD_HI = 4'd1,
      BYTE_PIX_LO  = 4'd2,
      BYTE_PIX_HI  = 4'd3,
      BYTE_EXP_LO  = 4'd4,
      BYTE_EXP_HI  = 4'd5,
      BYTE_MODE    = 4'd6,
      BYTE_INDEX   = 4'd7,
      BYTE_TAIL_LO = 4'd8,
      BYTE_TAIL_HI = 4'd9,
      BYTE_PIXEL   = 4'd10
   } byte_pos_type;

   typedef struct packed {
      logic [11:0] sample;
      logic        frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // one published pixel, with its header if it opens a frame
   typedef struct packed {
      logic        header;
      logic        last;
      logic [7:0]  frame_idx;
      logic [15:0] exposure;
      logic [11:0] sample;
      logic [11:0] level;
   } job_type;

   typedef struct packed {
      logic full;
      logic almost_full;
      logic empty;
   } q_status_type;

endpackage

@@ rtl/lccd_front.sv @@
// ---------------------------------------------------------------------------
// lccd_front: sample classification
// Tracks the readout position, the dark sum and the warmup count, and hands
// every published pixel to the queue in the cycle after it is accepted, with its dark level.
// ---------------------------------------------------------------------------
module lccd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  lccd_pkg::req_type      req_data,
   input  logic                   csr_we,
   input  lccd_pkg::csr_addr_type csr_addr,
   input  logic [15:0]            csr_wdata,
   output logic                   job_push,
   output lccd_pkg::job_type      job
);
   import lccd_pkg::*;

   localparam logic [IDX_W-1:0] SPF_C   = IDX_W'(SAMPLES_PER_FRAME);
   localparam logic [IDX_W-1:0] DARK_C  = IDX_W'(DARK_COUNT);
   localparam logic [IDX_W-1:0] DLAST_C = IDX_W'(DARK_COUNT - 1);
   localparam logic [IDX_W-1:0] WSTA_C  = IDX_W'(WIN_START);
   localparam logic [IDX_W-1:0] WEND_C  = IDX_W'(WIN_END);

   logic [15:0]      exposure_ff;
   logic [3:0]       warmup_ff;
   logic [IDX_W-1:0] sample_count_ff, sample_count_in;
   logic [15:0]      dark_sum_ff, dark_sum_in;
   logic [11:0]      dark_level_ff, dark_level_in;
   logic [3:0]       frames_seen_ff, frames_seen_in;
   logic [7:0]       frame_counter_ff, frame_counter_in;

   // second stage
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_dark_ff, s2_dark_in;
   job_type          s2_job_ff;

   logic [IDX_W-1:0] idx;
   logic             active;
   logic [15:0]      sum_base;
   logic [15:0]      sum_next;
   logic             publish;
   logic             in_window;
   logic             emit;
   logic [37:0]      dark_prod;
   logic [11:0]      level_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         exposure_ff <= EXPOSURE_RST;
         warmup_ff   <= WARMUP_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_EXPOSURE: exposure_ff <= csr_wdata;
            CSR_WARMUP:   warmup_ff   <= csr_wdata[3:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      idx       = req_data.frame_start ? '0 : sample_count_ff;
      active    = idx < SPF_C;
      sum_base  = (req_data.frame_start || idx == '0) ? 16'd0 : dark_sum_ff;
      sum_next  = sum_base + 16'(req_data.sample);
      publish   = frames_seen_ff >= warmup_ff;
      in_window = (idx >= WSTA_C) && (idx <= WEND_C);
      emit      = accept && active && publish && in_window;

      sample_count_in  = sample_count_ff;
      dark_sum_in      = dark_sum_ff;
      frames_seen_in   = frames_seen_ff;
      frame_counter_in = frame_counter_ff;
      s2_valid_in      = emit;
      s2_dark_in       = accept && active && (idx == DLAST_C);

      if (accept) begin
         if (req_data.frame_start) begin
            sample_count_in = '0;
            dark_sum_in     = 16'd0;
         end
         if (active) begin
            sample_count_in = idx + 1'b1;
            if (idx < DARK_C) begin
               dark_sum_in = sum_next;
            end
            if ((idx + 1'b1) == SPF_C && frames_seen_ff < warmup_ff
                && frames_seen_ff != FRAMES_MAX) begin
               frames_seen_in = frames_seen_ff + 4'd1;
            end
         end
         if (emit && idx == WSTA_C) begin
            frame_counter_in = frame_counter_ff + 8'd1;
         end
      end
   end

   // dark mean of the finished sum; used by the pixel in this stage as well
   always_comb begin
      dark_prod     = 38'(dark_sum_ff) * 38'(DARK_RECIP);
      level_new     = dark_prod[DARK_SHIFT +: 12];
      dark_level_in = s2_dark_ff ? level_new : dark_level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff  <= '0;
         dark_sum_ff      <= '0;
         dark_level_ff    <= '0;
         frames_seen_ff   <= '0;
         frame_counter_ff <= '0;
         s2_valid_ff      <= 1'b0;
         s2_dark_ff       <= 1'b0;
      end else begin
         sample_count_ff  <= sample_count_in;
         dark_sum_ff      <= dark_sum_in;
         dark_level_ff    <= dark_level_in;
         frames_seen_ff   <= frames_seen_in;
         frame_counter_ff <= frame_counter_in;
         s2_valid_ff      <= s2_valid_in;
         s2_dark_ff       <= s2_dark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_job_ff.header    <= (idx == WSTA_C);
         s2_job_ff.last      <= (idx == WEND_C);
         s2_job_ff.frame_idx <= frame_counter_ff + 8'd1;
         s2_job_ff.exposure  <= exposure_ff;
         s2_job_ff.sample    <= req_data.sample;
         s2_job_ff.level     <= '0;
      end
   end

   always_comb begin
      job       = s2_job_ff;
      job.level = dark_level_in;
      job_push  = s2_valid_ff;
   end

endmodule

@@ rtl/lccd_queue.sv @@
// ---------------------------------------------------------------------------
// lccd_queue: pixel job queue
// Short register queue between classification and byte serialisation.
// ---------------------------------------------------------------------------
module lccd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lccd_pkg::job_type      push_job,
   input  logic                   pop,
   output lccd_pkg::job_type      head,
   output lccd_pkg::q_status_type status
);
   import lccd_pkg::*;

   job_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
   localparam logic [QPTR_W:0]   CNT_FULL = (QPTR_W + 1)'(QDEPTH);
   localparam logic [QPTR_W:0]   CNT_HIGH = (QPTR_W + 1)'(QDEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_comb begin
      head               = mem_ff[rd_ptr_ff];
      status.full        = count_ff == CNT_FULL;
      status.almost_full = count_ff >= CNT_HIGH;
      status.empty       = count_ff == '0;
   end

endmodule

@@ rtl/lccd_back.sv @@
// ---------------------------------------------------------------------------
// lccd_back: byte serialiser
// Expands each queued job into the converted pixel byte, preceded by the header
// bytes when the job opens a frame, holding them in an output register for the receiver.
// ---------------------------------------------------------------------------
module lccd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lccd_pkg::job_type      head,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output lccd_pkg::rsp_type      rsp_data
);
   import lccd_pkg::*;

   byte_pos_type pos_ff, pos_in;
   byte_pos_type pos_eff;
   logic         out_valid_ff, out_valid_in;
   rsp_type      out_ff;
   rsp_type      next_rsp;
   logic         load;
   logic [11:0]  diff;
   logic [27:0]  pix_prod;
   logic [11:0]  quot;
   logic [7:0]   pix_byte;

   // pixel = clamp((level - sample) / 10), zero when the sample is brighter
   always_comb begin
      diff     = head.level - head.sample;
      pix_prod = 28'(diff) * 28'(PIX_RECIP);
      quot     = pix_prod[PIX_SHIFT +: 12];
      if (head.sample >= head.level) begin
         pix_byte = 8'd0;
      end else if (quot[11:8] != 4'd0) begin
         pix_byte = 8'hFF;
      end else begin
         pix_byte = quot[7:0];
      end
   end

   always_comb begin
      pos_eff       = head.header ? pos_ff : BYTE_PIXEL;
      next_rsp.last = 1'b0;
      unique case (pos_eff)
         BYTE_HEAD_LO: next_rsp.out_byte = HEAD_WORD[7:0];
         BYTE_HEAD_HI: next_rsp.out_byte = HEAD_WORD[15:8];
         BYTE_PIX_LO:  next_rsp.out_byte = PIX_WORD[7:0];
         BYTE_PIX_HI:  next_rsp.out_byte = PIX_WORD[15:8];
         BYTE_EXP_LO:  next_rsp.out_byte = head.exposure[7:0];
         BYTE_EXP_HI:  next_rsp.out_byte = head.exposure[15:8];
         BYTE_MODE:    next_rsp.out_byte = MODE_BYTE;
         BYTE_INDEX:   next_rsp.out_byte = head.frame_idx;
         BYTE_TAIL_LO: next_rsp.out_byte = TAIL_WORD[7:0];
         BYTE_TAIL_HI: next_rsp.out_byte = TAIL_WORD[15:8];
         default: begin
            next_rsp.out_byte = pix_byte;
            next_rsp.last     = head.last;
         end
      endcase

      load  = !q_empty && (!out_valid_ff || rsp_pop);
      q_pop = load && (pos_eff == BYTE_PIXEL);

      pos_in = pos_ff;
      if (load) begin
         pos_in = q_pop ? BYTE_HEAD_LO : byte_pos_type'(4'(pos_ff + 4'd1));
      end

      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= BYTE_HEAD_LO;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= next_rsp;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ rtl/linear_ccd_frame_builder.sv @@
// ---------------------------------------------------------------------------
// linear_ccd_frame_builder: linear CCD readout to packed frame bytes
// Dark-referenced pixel conversion with a framed, little-endian byte output.
// ---------------------------------------------------------------------------
// Usage:
//   Samples enter on req_push/req_full/req_data, one per cycle while req_full
//   is low; frame_start marks element 0 of a readout. Bytes leave on
//   rsp_empty/rsp_pop/rsp_data, header bytes first, the last window pixel
//   flagged. csr_we/csr_addr/csr_wdata write exposure (0) or warmup count (1).
//   Path: a published sample passes the dark-level stage, the job queue and
//   the output register on its way to rsp_data.
//   Throughput: one sample per cycle while req_full is low; a published
//   pixel yields one output byte, the frame's first eleven. The 16-entry job
//   queue takes up the header burst; req_full rises only once it nearly fills.
//   When the receiver stalls the output register holds its byte, the queue
//   fills and req_full then holds off the sender; nothing is dropped.
//   Reset clears position, dark level, warmup and frame counters, empties
//   the queue and sets exposure to 2000 us and warmup to five frames.
// ---------------------------------------------------------------------------
module linear_ccd_frame_builder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  lccd_pkg::req_type      req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output lccd_pkg::rsp_type      rsp_data,
   input  logic                   csr_we,
   input  lccd_pkg::csr_addr_type csr_addr,
   input  logic [15:0]            csr_wdata
);
   import lccd_pkg::*;

   logic         accept;
   logic         q_push;
   logic         q_pop;
   job_type      push_job;
   job_type      head;
   q_status_type q_status;

   // one slot kept for the job still in the dark-level stage
   assign req_full = q_status.full || (q_status.almost_full && q_push);
   assign accept   = req_push && !req_full;

   lccd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .job_push  (q_push),
      .job       (push_job)
   );

   lccd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head     (head),
      .status   (q_status)
   );

   lccd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_status.empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full && !q_pop))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("job queue underflow");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("output not empty after reset");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> req_full)
      else $error("input open while queue full");

endmodule
